FILE: hw/rtl/rrfc_pkg.sv
// rrfc_pkg: shared types, register indexes, status codes and the crc byte update
// for the read response frame checker; depends on nothing
package rrfc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CNT_W      = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TELEM_ADDR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEYCFG_ADDR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FUNC_CODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TELEM_BCNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEYCFG_BCNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TELEM_LEN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KEYCFG_LEN   = 3'd6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_LEN_ERR = 2'd1,
    STAT_HDR_ERR = 2'd2,
    STAT_CRC_ERR = 2'd3
  } status_t;

  // configuration register set
  typedef struct packed {
    logic [7:0] telem_addr;
    logic [7:0] keycfg_addr;
    logic [7:0] func_code;
    logic [7:0] telem_bcnt;
    logic [7:0] keycfg_bcnt;
    logic [7:0] telem_len;
    logic [7:0] keycfg_len;
  } cfg_t;

  // one received word
  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
    logic       last;
  } in_word_t;

  // one frame verdict
  typedef struct packed {
    status_t     status;
    logic [15:0] crc;
  } res_word_t;

  // crc-16/modbus update by one byte, reflected
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/read_response_frame_checker.sv
// Read response frame checker: one reply word per cycle, one status word per frame;
// a final word waits while the result register cannot load. The final byte is held in
// the input register and its verdict in the result register. Throughput: one byte every
// cycle unless a final word waits; the byte-wide crc update sits between the registers.
// Reset (synchronous, active low) loads the configuration defaults, empties both
// stages and clears the frame state. Depends on rrfc_pkg, rrfc_pipe_reg, rrfc_frame_core.
module read_response_frame_checker #(
  parameter int unsigned MAX_FRAME_BYTES = 255
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [rrfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // reply bytes
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_request_kind,
  input  logic [7:0]                      in_rx_byte,
  input  logic                            in_frame_end,
  // frame verdicts
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_frame_status,
  output logic [15:0]                     out_computed_crc
);

  localparam int unsigned IN_W  = $bits(rrfc_pkg::in_word_t);
  localparam int unsigned RES_W = $bits(rrfc_pkg::res_word_t);

  rrfc_pkg::cfg_t      cfg_r;
  rrfc_pkg::in_word_t  in_word;
  rrfc_pkg::in_word_t  stg_word;
  logic [IN_W-1:0]     stg_data;
  logic                stg_valid;
  logic                stg_ready;
  rrfc_pkg::res_word_t res_word;
  logic                res_valid;
  logic                res_ready;
  logic [RES_W-1:0]    out_data;
  rrfc_pkg::res_word_t out_word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.telem_addr  <= 8'd1;
      cfg_r.keycfg_addr <= 8'd1;
      cfg_r.func_code   <= 8'd3;
      cfg_r.telem_bcnt  <= 8'd124;
      cfg_r.keycfg_bcnt <= 8'd8;
      cfg_r.telem_len   <= 8'd129;
      cfg_r.keycfg_len  <= 8'd13;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrfc_pkg::REG_TELEM_ADDR:  cfg_r.telem_addr  <= cfg_wdata;
        rrfc_pkg::REG_KEYCFG_ADDR: cfg_r.keycfg_addr <= cfg_wdata;
        rrfc_pkg::REG_FUNC_CODE:   cfg_r.func_code   <= cfg_wdata;
        rrfc_pkg::REG_TELEM_BCNT:  cfg_r.telem_bcnt  <= cfg_wdata;
        rrfc_pkg::REG_KEYCFG_BCNT: cfg_r.keycfg_bcnt <= cfg_wdata;
        rrfc_pkg::REG_TELEM_LEN:   cfg_r.telem_len   <= cfg_wdata;
        rrfc_pkg::REG_KEYCFG_LEN:  cfg_r.keycfg_len  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input word register
  assign in_word.kind    = in_request_kind;
  assign in_word.rx_byte = in_rx_byte;
  assign in_word.last    = in_frame_end;

  rrfc_pipe_reg #(
    .WIDTH (IN_W)
  ) u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_word),
    .dn_valid (stg_valid),
    .dn_ready (stg_ready),
    .dn_data  (stg_data)
  );

  assign stg_word = rrfc_pkg::in_word_t'(stg_data);

  // frame checking logic
  rrfc_frame_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .word_valid (stg_valid),
    .word_ready (stg_ready),
    .word       (stg_word),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res_word)
  );

  // result word register
  rrfc_pipe_reg #(
    .WIDTH (RES_W)
  ) u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (res_valid),
    .up_ready (res_ready),
    .up_data  (res_word),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

  assign out_word         = rrfc_pkg::res_word_t'(out_data);
  assign out_frame_status = out_word.status;
  assign out_computed_crc = out_word.crc;

endmodule

FILE: hw/rtl/rrfc_pipe_reg.sv
// rrfc_pipe_reg: one valid/ready register stage, full rate
// standalone; used for the input and result stages of the frame checker
module rrfc_pipe_reg #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [WIDTH-1:0] up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [WIDTH-1:0] dn_data
);

  logic             valid_r;
  logic [WIDTH-1:0] data_r;

  // stage may load when empty or when its word leaves this cycle
  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= up_data;
    end
  end

endmodule

FILE: hw/rtl/rrfc_frame_core.sv
// rrfc_frame_core: per-frame state, header compare, crc accumulation and verdict
// depends on rrfc_pkg
module rrfc_frame_core #(
  parameter int unsigned MAX_FRAME_BYTES = 255
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rrfc_pkg::cfg_t      cfg,
  input  logic                word_valid,
  output logic                word_ready,
  input  rrfc_pkg::in_word_t  word,
  output logic                res_valid,
  input  logic                res_ready,
  output rrfc_pkg::res_word_t res
);

  localparam logic [rrfc_pkg::CNT_W-1:0] MAX_CNT = rrfc_pkg::CNT_W'(MAX_FRAME_BYTES);

  logic [15:0]                crc_r, crc_nxt;
  logic [rrfc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       hdr_r, hdr_nxt;
  logic [7:0]                 held0_r, held0_nxt;
  logic [7:0]                 held1_r, held1_nxt;
  logic                       kind_r, kind_nxt;

  logic                       fire;
  logic                       kind;
  logic                       hdr_upd;
  logic [15:0]                crc_upd;
  logic [rrfc_pkg::CNT_W-1:0] cnt_upd;
  logic [7:0]                 len_exp;
  logic [15:0]                wire_crc;
  rrfc_pkg::status_t          status;

  // a non-final word always passes; the final word waits for the result stage
  assign word_ready = !word.last || res_ready;
  assign fire       = word_valid && word_ready;
  assign res_valid  = word_valid && word.last;

  // per-word update
  always_comb begin
    kind    = (cnt_r == '0) ? word.kind : kind_r;
    hdr_upd = hdr_r;
    if (cnt_r == rrfc_pkg::CNT_W'(0)) begin
      if (word.rx_byte != (kind ? cfg.keycfg_addr : cfg.telem_addr)) hdr_upd = 1'b1;
    end else if (cnt_r == rrfc_pkg::CNT_W'(1)) begin
      if (word.rx_byte != cfg.func_code) hdr_upd = 1'b1;
    end else if (cnt_r == rrfc_pkg::CNT_W'(2)) begin
      if (word.rx_byte != (kind ? cfg.keycfg_bcnt : cfg.telem_bcnt)) hdr_upd = 1'b1;
    end
    crc_upd  = (cnt_r >= rrfc_pkg::CNT_W'(2)) ? rrfc_pkg::crc_byte(crc_r, held0_r) : crc_r;
    cnt_upd  = (cnt_r < MAX_CNT) ? cnt_r + rrfc_pkg::CNT_W'(1) : cnt_r;
    len_exp  = kind ? cfg.keycfg_len : cfg.telem_len;
    wire_crc = {word.rx_byte, held1_r};
  end

  // verdict, length first, then header, then crc
  always_comb begin
    priority if (cnt_upd != len_exp) begin
      status = rrfc_pkg::STAT_LEN_ERR;
    end else if (hdr_upd || cnt_upd < rrfc_pkg::CNT_W'(3)) begin
      status = rrfc_pkg::STAT_HDR_ERR;
    end else if (crc_upd != wire_crc) begin
      status = rrfc_pkg::STAT_CRC_ERR;
    end else begin
      status = rrfc_pkg::STAT_OK;
    end
    res.status = status;
    res.crc    = crc_upd;
  end

  // next state: advance on each word, clear after the final one
  always_comb begin
    crc_nxt   = crc_r;
    cnt_nxt   = cnt_r;
    hdr_nxt   = hdr_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    kind_nxt  = kind_r;
    if (fire) begin
      if (word.last) begin
        crc_nxt   = rrfc_pkg::CRC_INIT;
        cnt_nxt   = '0;
        hdr_nxt   = 1'b0;
        held0_nxt = '0;
        held1_nxt = '0;
        kind_nxt  = 1'b0;
      end else begin
        crc_nxt   = crc_upd;
        cnt_nxt   = cnt_upd;
        hdr_nxt   = hdr_upd;
        held0_nxt = held1_r;
        held1_nxt = word.rx_byte;
        kind_nxt  = kind;
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= rrfc_pkg::CRC_INIT;
      cnt_r   <= '0;
      hdr_r   <= 1'b0;
      held0_r <= '0;
      held1_r <= '0;
      kind_r  <= 1'b0;
    end else begin
      crc_r   <= crc_nxt;
      cnt_r   <= cnt_nxt;
      hdr_r   <= hdr_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // crc stays at its seed until the third byte has been shifted in
  a_crc_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r < rrfc_pkg::CNT_W'(3)) |-> (crc_r == rrfc_pkg::CRC_INIT))
    else $error("crc accumulated before third byte");

  // counter never passes its saturation value
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("byte counter beyond saturation");

  // a header flag only exists inside a frame
  a_hdr_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_r |-> (cnt_r != '0))
    else $error("header flag set outside a frame");

  // the final word of a frame clears the frame state
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && word.last) |=> (cnt_r == '0 && !hdr_r && crc_r == rrfc_pkg::CRC_INIT))
    else $error("frame state not cleared after final word");

endmodule

FILE: bench/testbench.sv
// testbench for the read response frame checker: random and directed reply frames,
// a self-contained frame verdict mirror and scoreboard; depends on rrfc_pkg and the rtl
`timescale 1ns / 100ps

module testbench;

  localparam int          FRAME_CAP     = 255;
  localparam logic [15:0] CRC_SEED      = 16'hFFFF;
  localparam logic [15:0] MODBUS_POLY   = 16'hA001;
  localparam logic [rrfc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int          RANDOM_WORDS  = 1750;
  localparam int          CALM_FROM     = 1500;
  localparam int          LONG_HOLD     = 96;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          QUIET_LIMIT   = 2000;

  // mirror of the frame checker and the store of verdicts still to come
  class reply_checker_mirror;
    rrfc_pkg::cfg_t      regs;
    logic [15:0]         crc_acc;
    logic [7:0]          nbytes;
    logic                hdr_bad;
    logic [7:0]          hold0;
    logic [7:0]          hold1;
    logic                kind_q;
    rrfc_pkg::res_word_t pending_verdicts[$];
    int unsigned         errors;

    function new();
      regs.telem_addr  = 8'd1;
      regs.keycfg_addr = 8'd1;
      regs.func_code   = 8'd3;
      regs.telem_bcnt  = 8'd124;
      regs.keycfg_bcnt = 8'd8;
      regs.telem_len   = 8'd129;
      regs.keycfg_len  = 8'd13;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      crc_acc = CRC_SEED;
      nbytes  = 8'd0;
      hdr_bad = 1'b0;
      hold0   = 8'd0;
      hold1   = 8'd0;
      kind_q  = 1'b0;
    endfunction

    // reflected crc-16, one data bit at a time
    function logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 0; i < 8; i++) begin
        fb = r[0] ^ b[i];
        r  = r >> 1;
        if (fb) r = r ^ MODBUS_POLY;
      end
      return r;
    endfunction

    function void set_reg(logic [rrfc_pkg::CFG_IDX_W-1:0] idx, logic [7:0] v);
      unique case (idx)
        rrfc_pkg::REG_TELEM_ADDR:  regs.telem_addr  = v;
        rrfc_pkg::REG_KEYCFG_ADDR: regs.keycfg_addr = v;
        rrfc_pkg::REG_FUNC_CODE:   regs.func_code   = v;
        rrfc_pkg::REG_TELEM_BCNT:  regs.telem_bcnt  = v;
        rrfc_pkg::REG_KEYCFG_BCNT: regs.keycfg_bcnt = v;
        rrfc_pkg::REG_TELEM_LEN:   regs.telem_len   = v;
        rrfc_pkg::REG_KEYCFG_LEN:  regs.keycfg_len  = v;
        default: ;
      endcase
    endfunction

    // one accepted reply word; a verdict is due on the frame's last byte
    function void take_word(logic kind, logic [7:0] b, logic fin);
      logic [7:0]          want;
      logic [7:0]          need_len;
      rrfc_pkg::res_word_t v;
      if (nbytes == 8'd0) kind_q = kind;
      if (nbytes == 8'd0) want = kind_q ? regs.keycfg_addr : regs.telem_addr;
      else if (nbytes == 8'd1) want = regs.func_code;
      else want = kind_q ? regs.keycfg_bcnt : regs.telem_bcnt;
      if (nbytes <= 8'd2 && b != want) hdr_bad = 1'b1;
      // the two newest bytes are held back as the wire crc
      if (nbytes >= 8'd2) crc_acc = crc16_step(crc_acc, hold0);
      hold0 = hold1;
      hold1 = b;
      if (nbytes < FRAME_CAP) nbytes++;
      if (fin) begin
        need_len = kind_q ? regs.keycfg_len : regs.telem_len;
        if (nbytes != need_len) v.status = rrfc_pkg::STAT_LEN_ERR;
        else if (hdr_bad || nbytes < 8'd3) v.status = rrfc_pkg::STAT_HDR_ERR;
        else if (crc_acc != {hold1, hold0}) v.status = rrfc_pkg::STAT_CRC_ERR;
        else v.status = rrfc_pkg::STAT_OK;
        v.crc = crc_acc;
        pending_verdicts.push_back(v);
        clear_frame();
      end
    endfunction

    function void match_verdict(logic [1:0] st, logic [15:0] crc);
      rrfc_pkg::res_word_t want;
      if (pending_verdicts.size() == 0) begin
        $error("verdict with none expected: frame_status %0d, computed_crc %h", st, crc);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (st !== want.status) begin
          $error("frame_status: expected %0d, actual %0d", want.status, st);
          errors++;
        end
        if (crc !== want.crc) begin
          $error("computed_crc: expected %h, actual %h", want.crc, crc);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return pending_verdicts.size();
    endfunction

    function bit all_clear();
      if (pending_verdicts.size() != 0)
        $error("%0d verdicts never arrived", pending_verdicts.size());
      return errors == 0 && pending_verdicts.size() == 0;
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [rrfc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rrfc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_request_kind = 1'b0;
  logic [7:0]                      in_rx_byte = 8'd0;
  logic                            in_frame_end = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [1:0]                      out_frame_status;
  logic [15:0]                     out_computed_crc;

  reply_checker_mirror mirror = new();
  logic [7:0] frame_bytes[$];
  bit         calm = 1'b0;
  int         hold_requests = 0;
  int         random_sent = 0;
  int         big_left = 0;

  read_response_frame_checker #(.MAX_FRAME_BYTES(FRAME_CAP)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_request_kind  (in_request_kind),
    .in_rx_byte       (in_rx_byte),
    .in_frame_end     (in_frame_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_status (out_frame_status),
    .out_computed_crc (out_computed_crc)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // offer one word at a falling edge and wait for its acceptance
  task automatic send_word(input logic kind, input logic [7:0] b, input logic fin);
    in_valid        = 1'b1;
    in_request_kind = kind;
    in_rx_byte      = b;
    in_frame_end    = fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror.take_word(kind, b, fin);
    @(negedge clk);
  endtask

  // send the current frame, kind on the first byte and junk kind afterwards
  task automatic send_frame(input logic kind);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (!calm && $urandom_range(0, 11) == 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      send_word(i == 0 ? kind : 1'($urandom_range(0, 1)), frame_bytes[i],
                i == frame_bytes.size() - 1);
      random_sent++;
      if (random_sent >= CALM_FROM) calm = 1'b1;
    end
  endtask

  // well-formed frame for the current settings, crc low byte first
  function automatic void build_frame(input logic kind, input int len);
    logic [15:0] c;
    frame_bytes.delete();
    repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
    if (len > 0) frame_bytes[0] = kind ? mirror.regs.keycfg_addr : mirror.regs.telem_addr;
    if (len > 1) frame_bytes[1] = mirror.regs.func_code;
    if (len > 2) frame_bytes[2] = kind ? mirror.regs.keycfg_bcnt : mirror.regs.telem_bcnt;
    if (len >= 2) begin
      c = CRC_SEED;
      for (int i = 0; i < len - 2; i++) c = mirror.crc16_step(c, frame_bytes[i]);
      frame_bytes[len-2] = c[7:0];
      frame_bytes[len-1] = c[15:8];
    end
  endfunction

  // wait until every verdict is in and the pipeline has emptied
  task automatic settle();
    in_valid = 1'b0;
    while (mirror.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_reg(input logic [rrfc_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] v);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    mirror.set_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [7:0] ta, input logic [7:0] ka,
                               input logic [7:0] fc, input logic [7:0] tb,
                               input logic [7:0] kb, input logic [7:0] tl,
                               input logic [7:0] kl);
    settle();
    load_reg(rrfc_pkg::REG_TELEM_ADDR, ta);
    load_reg(rrfc_pkg::REG_KEYCFG_ADDR, ka);
    load_reg(rrfc_pkg::REG_FUNC_CODE, fc);
    load_reg(rrfc_pkg::REG_TELEM_BCNT, tb);
    load_reg(rrfc_pkg::REG_KEYCFG_BCNT, kb);
    load_reg(rrfc_pkg::REG_TELEM_LEN, tl);
    load_reg(rrfc_pkg::REG_KEYCFG_LEN, kl);
    cfg_we = 1'b0;
  endtask

  // mostly good frames, the rest with bad header, bad crc, wrong length or noise
  task automatic run_phase(input int budget);
    int   goal;
    int   cfg_len;
    int   len;
    int   pick;
    logic k;
    goal = random_sent + budget;
    while (random_sent < goal) begin
      k       = 1'($urandom_range(0, 1));
      cfg_len = int'(k ? mirror.regs.keycfg_len : mirror.regs.telem_len);
      pick    = $urandom_range(0, 99);
      if (cfg_len == 0) len = $urandom_range(1, 8);
      else len = cfg_len;
      if (cfg_len > 32) begin
        if (big_left == 0) begin
          len = $urandom_range(1, 12);
        end else begin
          big_left--;
          // past the cap the count saturates
          if (cfg_len == FRAME_CAP && $urandom_range(0, 1) == 1) len = len + $urandom_range(1, 4);
        end
      end
      if (pick >= 78 && pick < 86) begin
        if ($urandom_range(0, 1) == 1 && len > 1) len = len - 1;
        else len = len + $urandom_range(1, 3);
      end
      build_frame(k, len);
      if (pick >= 60 && pick < 70) begin
        frame_bytes[$urandom_range(0, len > 3 ? 2 : len - 1)] ^= 8'h01 << $urandom_range(0, 7);
      end else if (pick >= 70 && pick < 78 && len >= 2) begin
        frame_bytes[len - 1 - $urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
      end else if (pick >= 86 && pick < 94) begin
        foreach (frame_bytes[i]) frame_bytes[i] = 8'($urandom_range(0, 255));
      end else if (pick >= 94) begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 2)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      send_frame(k);
    end
  endtask

  // result side: check accepted verdicts, stall in bursts or in one long hold
  initial begin : verdict_sink
    int stall_left;
    int hold_left;
    int holds_done;
    stall_left = 0;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        mirror.match_verdict(out_frame_status, out_computed_crc);
      @(negedge clk);
      if (holds_done < hold_requests) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_ready  = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // one and two byte frames under reset values
    frame_bytes = '{8'h00};
    send_frame(1'b0);
    frame_bytes = '{8'hFF, 8'h00};
    send_frame(1'b1);

    // index past the register list, then a two-byte length and a zero length
    settle();
    load_reg(REG_UNUSED, 8'hFF);
    cfg_we = 1'b0;
    load_settings(8'h01, 8'h01, 8'h03, 8'd124, 8'd8, 8'd2, 8'd0);
    frame_bytes = '{8'h01, 8'h03};
    send_frame(1'b0);
    frame_bytes = '{8'h5A};
    send_frame(1'b1);

    // minimal frames: good, three bytes, bad crc, bad function byte
    load_settings(8'h01, 8'h7E, 8'h03, 8'h00, 8'hFA, 8'd5, 8'd3);
    build_frame(1'b0, 5);
    send_frame(1'b0);
    build_frame(1'b1, 3);
    send_frame(1'b1);
    build_frame(1'b0, 5);
    frame_bytes[4] ^= 8'h80;
    send_frame(1'b0);
    build_frame(1'b0, 5);
    frame_bytes[1] = ~frame_bytes[1];
    send_frame(1'b0);

    // random part: reset values with a couple of long telemetry frames
    load_settings(8'd1, 8'd1, 8'd3, 8'd124, 8'd8, 8'd129, 8'd13);
    big_left = 2;
    run_phase(260);

    // all-zero header, receiver holds off so the checker backs up
    load_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd6, 8'd5);
    hold_requests++;
    run_phase(200);

    // top of every header range
    load_settings(8'hFF, 8'hFF, 8'hFF, 8'd250, 8'd250, 8'd8, 8'd20);
    run_phase(200);

    // longest telemetry length and a key config length that never matches
    load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 250)),
                  8'($urandom_range(0, 250)), 8'd255, 8'd0);
    big_left = 2;
    run_phase(560);

    // random settings with short frames for the rest
    while (random_sent < RANDOM_WORDS) begin
      load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 250)),
                    8'($urandom_range(0, 250)), 8'($urandom_range(3, 24)),
                    8'($urandom_range(3, 24)));
      run_phase(150);
    end

    // drain and report
    in_valid = 1'b0;
    while (mirror.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mirror.all_clear()) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: read_response_frame_checker.f
hw/rtl/rrfc_pkg.sv
hw/rtl/rrfc_pipe_reg.sv
hw/rtl/rrfc_frame_core.sv
hw/rtl/read_response_frame_checker.sv
bench/testbench.sv
